FILE: hw/rtl/lew_pkg.sv
// Shared constants, types and controller/datapath interface for the line editor.
`timescale 1ns / 1ps
`default_nettype none

package lew_pkg;

    localparam int LINE_CAPACITY = 64;
    localparam int MAX_RESULTS   = 64;
    localparam int WIDTH_CAP     = (LINE_CAPACITY < MAX_RESULTS) ? LINE_CAPACITY : MAX_RESULTS;
    localparam int ADDR_W        = $clog2(LINE_CAPACITY);
    localparam int LEN_W         = $clog2(LINE_CAPACITY + 1);

    localparam int KEY_W      = 8;
    localparam int GLYPH_W    = 7;
    localparam int COUNT_W    = 7;
    localparam int ACT_W      = 3;
    localparam int CFG_W      = 7;
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;
    localparam int REG_IDX_W  = PADDR_W - 2;

    localparam logic [CFG_W-1:0]     WIDTH_RESET    = 7'd40;
    localparam logic [REG_IDX_W-1:0] REG_LINE_WIDTH = '0;

    localparam logic [KEY_W-1:0] KEY_EOF    = 8'd4;
    localparam logic [KEY_W-1:0] KEY_LF     = 8'd10;
    localparam logic [KEY_W-1:0] KEY_CR     = 8'd13;
    localparam logic [KEY_W-1:0] KEY_KILL   = 8'd21;
    localparam logic [KEY_W-1:0] KEY_WERASE = 8'd23;
    localparam logic [KEY_W-1:0] KEY_SPACE  = 8'd32;
    localparam logic [KEY_W-1:0] KEY_TILDE  = 8'd126;
    localparam logic [KEY_W-1:0] KEY_DEL    = 8'd127;

    localparam logic [GLYPH_W-1:0] GLYPH_SPACE = 7'd32;

    typedef enum logic [ACT_W-1:0] {
        ACT_ECHO    = 3'd0,
        ACT_ERASE   = 3'd1,
        ACT_KILL    = 3'd2,
        ACT_BEEP    = 3'd3,
        ACT_NEWLINE = 3'd4,
        ACT_BREAK   = 3'd5,
        ACT_END     = 3'd6
    } action_t;

    typedef enum logic [2:0] {
        KC_EOF,
        KC_DEL,
        KC_KILL,
        KC_WERASE,
        KC_PRINT,
        KC_NEWLINE,
        KC_OTHER
    } key_class_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_WE_SP,
        ST_WE_WD,
        ST_WE_DONE,
        ST_WR_SCAN,
        ST_WR_BREAK,
        ST_COPY
    } state_t;

    typedef enum logic [2:0] {
        LEN_HOLD,
        LEN_INC,
        LEN_DEC,
        LEN_ZERO,
        LEN_SUB_PTR,
        LEN_TO_PTR
    } len_op_t;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_LEN,
        PTR_LEN_M1,
        PTR_DEC,
        PTR_INC
    } ptr_op_t;

    typedef enum logic [2:0] {
        RD_LEN_M1,
        RD_PTR,
        RD_PTR_M1,
        RD_PTR_M2,
        RD_SRC
    } rd_sel_t;

    typedef enum logic {
        WR_KEY,
        WR_COPY
    } wr_sel_t;

    typedef enum logic [1:0] {
        CNT_ZERO,
        CNT_ONE,
        CNT_LEN,
        CNT_LEN_SUB_PTR
    } cnt_sel_t;

    typedef enum logic [2:0] {
        LL_ZERO,
        LL_LEN,
        LL_LEN_M1,
        LL_LEN_P1,
        LL_PTR,
        LL_DST_P1
    } ll_sel_t;

    typedef enum logic [1:0] {
        GL_ZERO,
        GL_KEY,
        GL_RDATA
    } glyph_sel_t;

    typedef struct packed {
        logic       key_load;
        logic       fin_set;
        len_op_t    len_op;
        ptr_op_t    ptr_op;
        logic       rd_en;
        rd_sel_t    rd_sel;
        logic       wr_en;
        wr_sel_t    wr_sel;
        logic       copy_init;
        logic       copy_step;
        logic       out_load;
        action_t    out_act;
        cnt_sel_t   cnt_sel;
        ll_sel_t    ll_sel;
        glyph_sel_t glyph_sel;
        logic       out_last;
    } cmd_t;

    typedef struct packed {
        key_class_t key_class;
        logic       fin;
        logic       len_zero;
        logic       len_full;
        logic       len_wrap;
        logic       key_space;
        logic       ptr_zero;
        logic       ptr_one;
        logic       rd_space;
        logic       copy_last;
        logic       out_free;
    } sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lew_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module lew_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/lew_datapath.sv
// Line editor datapath: key register, line store, length, pointers and result register.
`timescale 1ns / 1ps
`default_nettype none

module lew_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [lew_pkg::KEY_W-1:0]     s_key_byte,
    input  wire logic [lew_pkg::CFG_W-1:0]     line_width,
    input  wire lew_pkg::cmd_t                 cmd,
    output lew_pkg::sts_t                      sts,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [lew_pkg::ACT_W-1:0]     m_action,
    output logic      [lew_pkg::GLYPH_W-1:0]   m_glyph,
    output logic      [lew_pkg::COUNT_W-1:0]   m_count,
    output logic      [lew_pkg::COUNT_W-1:0]   m_line_length,
    output logic                               m_last
);

    import lew_pkg::*;

    logic [KEY_W-1:0]   key_reg;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic               fin_reg, fin_next;
    logic [LEN_W-1:0]   ptr_reg, ptr_next;
    logic [LEN_W-1:0]   src_reg, src_next;
    logic [LEN_W-1:0]   dst_reg, dst_next;
    logic               out_valid_reg, out_valid_next;
    action_t            out_act_reg;
    logic [GLYPH_W-1:0] out_glyph_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic [COUNT_W-1:0] out_len_reg;
    logic               out_last_reg;

    logic [LEN_W-1:0]   eff_w;
    logic [LEN_W-1:0]   len_m1, len_p1, ptr_m1, ptr_m2, ptr_p1, len_sub_ptr, dst_p1;
    logic [ADDR_W-1:0]  raddr, waddr;
    logic [GLYPH_W-1:0] wdata, rdata;
    logic               out_free;
    logic [LEN_W-1:0]   cnt_val, ll_val;
    logic [GLYPH_W-1:0] glyph_val;

    lew_ram #(
        .WIDTH(GLYPH_W),
        .DEPTH(LINE_CAPACITY)
    ) u_line_store (
        .aclk  (aclk),
        .we    (cmd.wr_en),
        .waddr (waddr),
        .wdata (wdata),
        .re    (cmd.rd_en),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb begin
        eff_w = (int'(line_width) > WIDTH_CAP) ? LEN_W'(WIDTH_CAP) : LEN_W'(line_width);
        len_m1      = len_reg - LEN_W'(1);
        len_p1      = len_reg + LEN_W'(1);
        ptr_m1      = ptr_reg - LEN_W'(1);
        ptr_m2      = ptr_reg - LEN_W'(2);
        ptr_p1      = ptr_reg + LEN_W'(1);
        len_sub_ptr = len_reg - ptr_reg;
        dst_p1      = dst_reg + LEN_W'(1);
        out_free    = !out_valid_reg || m_ready;
    end

    always_comb begin
        unique case (cmd.rd_sel)
            RD_LEN_M1: raddr = len_m1[ADDR_W-1:0];
            RD_PTR:    raddr = ptr_reg[ADDR_W-1:0];
            RD_PTR_M1: raddr = ptr_m1[ADDR_W-1:0];
            RD_PTR_M2: raddr = ptr_m2[ADDR_W-1:0];
            RD_SRC:    raddr = src_reg[ADDR_W-1:0];
            default:   raddr = src_reg[ADDR_W-1:0];
        endcase
        if (cmd.wr_sel == WR_KEY) begin
            waddr = len_reg[ADDR_W-1:0];
            wdata = key_reg[GLYPH_W-1:0];
        end else begin
            waddr = dst_reg[ADDR_W-1:0];
            wdata = rdata;
        end
    end

    always_comb begin
        sts.fin       = fin_reg;
        sts.len_zero  = (len_reg == '0);
        sts.len_full  = (len_reg >= eff_w);
        sts.len_wrap  = ((LEN_W+1)'(len_reg) + (LEN_W+1)'(1)) >= (LEN_W+1)'(eff_w);
        sts.key_space = (key_reg == KEY_SPACE);
        sts.ptr_zero  = (ptr_reg == '0);
        sts.ptr_one   = (ptr_reg == LEN_W'(1));
        sts.rd_space  = (rdata == GLYPH_SPACE);
        sts.copy_last = (dst_p1 == len_reg);
        sts.out_free  = out_free;
        unique case (key_reg) inside
            KEY_EOF:              sts.key_class = KC_EOF;
            KEY_DEL:              sts.key_class = KC_DEL;
            KEY_KILL:             sts.key_class = KC_KILL;
            KEY_WERASE:           sts.key_class = KC_WERASE;
            KEY_CR, KEY_LF:       sts.key_class = KC_NEWLINE;
            [KEY_SPACE:KEY_TILDE]: sts.key_class = KC_PRINT;
            default:              sts.key_class = KC_OTHER;
        endcase
    end

    always_comb begin
        unique case (cmd.len_op)
            LEN_HOLD:    len_next = len_reg;
            LEN_INC:     len_next = len_p1;
            LEN_DEC:     len_next = len_m1;
            LEN_ZERO:    len_next = '0;
            LEN_SUB_PTR: len_next = len_sub_ptr;
            LEN_TO_PTR:  len_next = ptr_reg;
            default:     len_next = len_reg;
        endcase
        unique case (cmd.ptr_op)
            PTR_HOLD:   ptr_next = ptr_reg;
            PTR_LEN:    ptr_next = len_reg;
            PTR_LEN_M1: ptr_next = len_m1;
            PTR_DEC:    ptr_next = ptr_m1;
            PTR_INC:    ptr_next = ptr_p1;
            default:    ptr_next = ptr_reg;
        endcase
        src_next = src_reg;
        dst_next = dst_reg;
        if (cmd.copy_init) begin
            src_next = ptr_p1;
            dst_next = '0;
        end else if (cmd.copy_step) begin
            src_next = src_reg + LEN_W'(1);
            dst_next = dst_p1;
        end
        fin_next       = fin_reg || cmd.fin_set;
        out_valid_next = cmd.out_load || (out_valid_reg && !m_ready);
    end

    always_comb begin
        unique case (cmd.cnt_sel)
            CNT_ZERO:        cnt_val = '0;
            CNT_ONE:         cnt_val = LEN_W'(1);
            CNT_LEN:         cnt_val = len_reg;
            CNT_LEN_SUB_PTR: cnt_val = len_sub_ptr;
            default:         cnt_val = '0;
        endcase
        unique case (cmd.ll_sel)
            LL_ZERO:   ll_val = '0;
            LL_LEN:    ll_val = len_reg;
            LL_LEN_M1: ll_val = len_m1;
            LL_LEN_P1: ll_val = len_p1;
            LL_PTR:    ll_val = ptr_reg;
            LL_DST_P1: ll_val = dst_p1;
            default:   ll_val = '0;
        endcase
        unique case (cmd.glyph_sel)
            GL_ZERO:  glyph_val = '0;
            GL_KEY:   glyph_val = key_reg[GLYPH_W-1:0];
            GL_RDATA: glyph_val = rdata;
            default:  glyph_val = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg       <= '0;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            len_reg       <= len_next;
            fin_reg       <= fin_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.key_load) begin
            key_reg <= s_key_byte;
        end
        ptr_reg <= ptr_next;
        src_reg <= src_next;
        dst_reg <= dst_next;
        if (cmd.out_load) begin
            out_act_reg   <= cmd.out_act;
            out_glyph_reg <= glyph_val;
            out_count_reg <= COUNT_W'(cnt_val);
            out_len_reg   <= COUNT_W'(ll_val);
            out_last_reg  <= cmd.out_last;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_action      = out_act_reg;
    assign m_glyph       = out_glyph_reg;
    assign m_count       = out_count_reg;
    assign m_line_length = out_len_reg;
    assign m_last        = out_last_reg;

    // A new word must never overwrite a result that has not been taken.
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> out_free)
        else $error("Result word loaded while the previous one is still pending.");

    // The store is never read and written at the same entry in one cycle.
    a_rw_apart: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.rd_en && cmd.wr_en) |-> (raddr != waddr))
        else $error("Line store read and write collide.");

    a_fin_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_reg |=> fin_reg)
        else $error("Session end flag cleared without reset.");

    a_len_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_W'(WIDTH_CAP))
        else $error("Line length exceeds the store capacity.");

endmodule

`default_nettype wire

FILE: hw/rtl/lew_ctrl.sv
// Line editor controller: keystroke sequencing, word scans and wrap copy.
`timescale 1ns / 1ps
`default_nettype none

module lew_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire lew_pkg::sts_t sts,
    output lew_pkg::cmd_t      cmd
);

    import lew_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready      = 1'b1;
                cmd.key_load = s_valid;
                if (s_valid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (sts.fin) begin
                    state_next = ST_IDLE;
                end else begin
                    unique case (sts.key_class)
                        KC_EOF: begin
                            if (!sts.len_zero) begin
                                state_next = ST_IDLE;
                            end else if (sts.out_free) begin
                                cmd.out_load = 1'b1;
                                cmd.out_act  = ACT_END;
                                cmd.out_last = 1'b1;
                                cmd.fin_set  = 1'b1;
                                state_next   = ST_IDLE;
                            end
                        end
                        KC_DEL: begin
                            if (sts.out_free) begin
                                cmd.out_load = 1'b1;
                                cmd.out_last = 1'b1;
                                if (sts.len_zero) begin
                                    cmd.out_act = ACT_BEEP;
                                    cmd.ll_sel  = LL_LEN;
                                end else begin
                                    cmd.out_act = ACT_ERASE;
                                    cmd.cnt_sel = CNT_ONE;
                                    cmd.ll_sel  = LL_LEN_M1;
                                    cmd.len_op  = LEN_DEC;
                                end
                                state_next = ST_IDLE;
                            end
                        end
                        KC_KILL: begin
                            if (sts.out_free) begin
                                cmd.out_load = 1'b1;
                                cmd.out_last = 1'b1;
                                if (sts.len_zero) begin
                                    cmd.out_act = ACT_BEEP;
                                    cmd.ll_sel  = LL_LEN;
                                end else begin
                                    cmd.out_act = ACT_KILL;
                                    cmd.cnt_sel = CNT_LEN;
                                    cmd.ll_sel  = LL_ZERO;
                                    cmd.len_op  = LEN_ZERO;
                                end
                                state_next = ST_IDLE;
                            end
                        end
                        KC_WERASE: begin
                            if (sts.len_zero) begin
                                state_next = ST_IDLE;
                            end else begin
                                cmd.ptr_op = PTR_LEN;
                                cmd.rd_en  = 1'b1;
                                cmd.rd_sel = RD_LEN_M1;
                                state_next = ST_WE_SP;
                            end
                        end
                        KC_PRINT: begin
                            if (sts.len_full || (sts.len_wrap && !sts.key_space && sts.len_zero))
                            begin
                                if (sts.out_free) begin
                                    cmd.out_load = 1'b1;
                                    cmd.out_last = 1'b1;
                                    cmd.out_act  = ACT_BEEP;
                                    cmd.ll_sel   = LL_LEN;
                                    state_next   = ST_IDLE;
                                end
                            end else if (!sts.len_wrap) begin
                                if (sts.out_free) begin
                                    cmd.wr_en     = 1'b1;
                                    cmd.wr_sel    = WR_KEY;
                                    cmd.len_op    = LEN_INC;
                                    cmd.out_load  = 1'b1;
                                    cmd.out_last  = 1'b1;
                                    cmd.out_act   = ACT_ECHO;
                                    cmd.glyph_sel = GL_KEY;
                                    cmd.ll_sel    = LL_LEN_P1;
                                    state_next    = ST_IDLE;
                                end
                            end else if (sts.key_space) begin
                                if (sts.out_free) begin
                                    cmd.len_op   = LEN_ZERO;
                                    cmd.out_load = 1'b1;
                                    cmd.out_last = 1'b1;
                                    cmd.out_act  = ACT_BREAK;
                                    cmd.cnt_sel  = CNT_ZERO;
                                    cmd.ll_sel   = LL_ZERO;
                                    state_next   = ST_IDLE;
                                end
                            end else begin
                                cmd.wr_en  = 1'b1;
                                cmd.wr_sel = WR_KEY;
                                cmd.len_op = LEN_INC;
                                cmd.ptr_op = PTR_LEN_M1;
                                cmd.rd_en  = 1'b1;
                                cmd.rd_sel = RD_LEN_M1;
                                state_next = ST_WR_SCAN;
                            end
                        end
                        KC_NEWLINE: begin
                            if (sts.out_free) begin
                                cmd.out_load = 1'b1;
                                cmd.out_last = 1'b1;
                                cmd.out_act  = ACT_NEWLINE;
                                cmd.ll_sel   = LL_ZERO;
                                cmd.len_op   = LEN_ZERO;
                                state_next   = ST_IDLE;
                            end
                        end
                        default: begin
                            if (sts.out_free) begin
                                cmd.out_load = 1'b1;
                                cmd.out_last = 1'b1;
                                cmd.out_act  = ACT_BEEP;
                                cmd.ll_sel   = LL_LEN;
                                state_next   = ST_IDLE;
                            end
                        end
                    endcase
                end
            end
            ST_WE_SP: begin
                cmd.ptr_op = PTR_DEC;
                if (sts.ptr_one) begin
                    state_next = ST_WE_DONE;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_PTR_M2;
                    if (!sts.rd_space) begin
                        state_next = ST_WE_WD;
                    end
                end
            end
            ST_WE_WD: begin
                if (sts.rd_space) begin
                    state_next = ST_WE_DONE;
                end else begin
                    cmd.ptr_op = PTR_DEC;
                    if (sts.ptr_one) begin
                        state_next = ST_WE_DONE;
                    end else begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_PTR_M2;
                    end
                end
            end
            ST_WE_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = 1'b1;
                    cmd.out_act  = ACT_ERASE;
                    cmd.cnt_sel  = CNT_LEN_SUB_PTR;
                    cmd.ll_sel   = LL_PTR;
                    cmd.len_op   = LEN_TO_PTR;
                    state_next   = ST_IDLE;
                end
            end
            ST_WR_SCAN: begin
                if (!sts.rd_space && !sts.ptr_zero) begin
                    cmd.ptr_op = PTR_DEC;
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_PTR_M1;
                end else if (sts.rd_space) begin
                    cmd.ptr_op = PTR_INC;
                    state_next = ST_WR_BREAK;
                end else if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = 1'b1;
                    cmd.out_act  = ACT_BEEP;
                    cmd.ll_sel   = LL_LEN_M1;
                    cmd.len_op   = LEN_DEC;
                    state_next   = ST_IDLE;
                end
            end
            ST_WR_BREAK: begin
                if (sts.out_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.out_act   = ACT_BREAK;
                    cmd.cnt_sel   = CNT_LEN_SUB_PTR;
                    cmd.ll_sel    = LL_ZERO;
                    cmd.len_op    = LEN_SUB_PTR;
                    cmd.copy_init = 1'b1;
                    cmd.rd_en     = 1'b1;
                    cmd.rd_sel    = RD_PTR;
                    state_next    = ST_COPY;
                end
            end
            ST_COPY: begin
                if (sts.out_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.out_act   = ACT_ECHO;
                    cmd.glyph_sel = GL_RDATA;
                    cmd.ll_sel    = LL_DST_P1;
                    cmd.out_last  = sts.copy_last;
                    cmd.wr_en     = 1'b1;
                    cmd.wr_sel    = WR_COPY;
                    cmd.copy_step = 1'b1;
                    if (sts.copy_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_SRC;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/line_editor_erase_kill_wrap_core.sv
// Terminal line editor with erase, kill, word erase and word wrap.
// Keystroke words enter on the s_ channel (s_valid/s_ready, s_key_byte) and display
// action words leave on the m_ channel (m_valid/m_ready, action, glyph, count,
// line_length, last); last marks the final word caused by one keystroke.
// The line width register sits at byte address 0 of the APB port; pready is always high.
// One keystroke is taken at a time. A simple key is decoded from the key register and its
// word is loaded into the output register once that register is free. Word erase walks the
// line store back one entry per cycle. A wrap walks back over the last word (one store read
// per cycle), then moves it to the line start at one character per cycle while the receiver
// keeps up, one echo word each. The single read port of the line store paces these walks.
// s_ready is high again as soon as the last word is in the output register, so the next
// keystroke is taken while that word waits. When the receiver stalls, the block holds
// its word and waits before writing the next one; nothing is dropped.
// Reset empties the line, clears the session end flag and sets the width to 40; the
// store contents are not cleared, as only entries below the length are ever read.
`timescale 1ns / 1ps
`default_nettype none

module line_editor_erase_kill_wrap_core (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [lew_pkg::KEY_W-1:0]         s_key_byte,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic      [lew_pkg::ACT_W-1:0]         m_action,
    output logic      [lew_pkg::GLYPH_W-1:0]       m_glyph,
    output logic      [lew_pkg::COUNT_W-1:0]       m_count,
    output logic      [lew_pkg::COUNT_W-1:0]       m_line_length,
    output logic                                   m_last,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [lew_pkg::PADDR_W-1:0]       paddr,
    input  wire logic [lew_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [lew_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                   pready
);

    import lew_pkg::*;

    logic [CFG_W-1:0]     width_reg, width_next;
    logic [REG_IDX_W-1:0] reg_idx;
    cmd_t                 cmd;
    sts_t                 sts;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign pready  = 1'b1;

    always_comb begin
        width_next = width_reg;
        if (psel && penable && pwrite && (reg_idx == REG_LINE_WIDTH)) begin
            width_next = pwdata[CFG_W-1:0];
        end
        prdata = '0;
        if (reg_idx == REG_LINE_WIDTH) begin
            prdata[CFG_W-1:0] = width_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= WIDTH_RESET;
        end else begin
            width_reg <= width_next;
        end
    end

    lew_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    lew_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_key_byte    (s_key_byte),
        .line_width    (width_reg),
        .cmd           (cmd),
        .sts           (sts),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_action      (m_action),
        .m_glyph       (m_glyph),
        .m_count       (m_count),
        .m_line_length (m_line_length),
        .m_last        (m_last)
    );

endmodule

`default_nettype wire
